FILE: design/printable_string_extractor_unit_defines.svh
// Assertion macros used by the checker file of the printable string extractor.
// Needs signals named clock and reset in the scope where the macros are used.
`ifndef PRINTABLE_STRING_EXTRACTOR_UNIT_DEFINES_SVH
`define PRINTABLE_STRING_EXTRACTOR_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("printable string extractor check failed");

// Consequent checked in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("printable string extractor check failed");

`endif

FILE: design/pse_pkg.sv
// Package of the printable string extractor: beat types, register codes and constants.
// Used by printable_string_extractor_unit and pse_checker; depends on nothing.
package pse_pkg;

   localparam int MAX_MIN_LEN_DEF = 16;
   localparam int MAX_RUN_LEN_DEF = 4096;

   localparam int CHAR_W       = 7;
   localparam int BYTE_W       = 8;
   localparam int MIN_LENGTH_W = 5;
   localparam int MAX_LENGTH_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

   localparam logic [MIN_LENGTH_W-1:0] MIN_LENGTH_RESET = 5'd4;
   localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RESET = 13'd4096;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH = 1'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_data;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              string_end;
      logic              last;
   } rsp_type;

endpackage

FILE: design/printable_string_extractor_unit.sv
// Top level of the printable string extractor: run tracking, held bytes and result register.
// Depends on pse_pkg for the beat types, register codes and constants.
//
// Usage: bytes arrive on the req_ channel (valid/stall), one beat per byte or an
// end-of-data beat. Characters of qualifying strings and end markers leave on the
// rsp_ channel, one result per beat, with last set on the final result of an input.
// The csr_ port writes min_length (index 0) and max_length (index 1); the user must
// write them only while idle, as the block itself does not enforce it. The first result
// of a byte appears in the output register in the cycle after the byte is accepted.
// One byte is taken per cycle while req_stall is low. When a run reaches min_length,
// its held bytes and the current byte leave as a burst of up to MAX_MIN_LEN beats,
// one per cycle while rsp_stall is low, fed from the held-byte register file; req_stall
// stays high for the burst, so no further byte is taken until it ends. A stall on
// rsp_stall holds the output register and raises req_stall in the same cycle. Reset
// clears the run count, the output register and any burst, and restores min_length 4
// and max_length 4096; held bytes have no reset.
module printable_string_extractor_unit #(
   parameter int MAX_MIN_LEN = pse_pkg::MAX_MIN_LEN_DEF,
   parameter int MAX_RUN_LEN = pse_pkg::MAX_RUN_LEN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pse_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pse_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_write_en,
   input  logic [pse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pse_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int CNT_W    = $clog2(MAX_RUN_LEN);
   localparam int CMP_W    = ((CNT_W > pse_pkg::MAX_LENGTH_W) ? CNT_W : pse_pkg::MAX_LENGTH_W) + 1;
   localparam int HELD_N   = MAX_MIN_LEN - 1;
   localparam int HELD_AW  = (HELD_N > 1) ? $clog2(HELD_N) : 1;
   localparam int IDX_W    = $clog2(MAX_MIN_LEN);

   logic [pse_pkg::MIN_LENGTH_W-1:0] min_length_ff;
   logic [pse_pkg::MAX_LENGTH_W-1:0] max_length_ff;
   logic [CNT_W-1:0]                 run_count_ff, run_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pse_pkg::rsp_type                 rsp_payload_ff, rsp_payload_in;
   logic                             flush_active_ff, flush_active_in;
   logic [IDX_W-1:0]                 flush_idx_ff, flush_idx_in;
   logic [IDX_W-1:0]                 flush_nh_ff, flush_nh_in;
   logic [pse_pkg::CHAR_W-1:0]       flush_char_ff, flush_char_in;
   logic [pse_pkg::CHAR_W-1:0]       held_ff [HELD_N];

   logic                             held_we;
   logic [HELD_AW-1:0]               held_waddr;
   logic                             out_free;
   logic                             req_accept;
   logic                             printable;
   logic [CMP_W-1:0]                 run_ext;
   logic [CMP_W-1:0]                 min_ext;
   logic [CMP_W-1:0]                 max_ext;
   logic [CMP_W-1:0]                 eff_min;
   logic [CMP_W-1:0]                 eff_cap;
   logic [pse_pkg::CHAR_W-1:0]       cur_char;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = flush_active_ff || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign run_ext = CMP_W'(run_count_ff);
   assign min_ext = CMP_W'(min_length_ff);
   assign max_ext = CMP_W'(max_length_ff);
   assign cur_char = req_payload.in_byte[pse_pkg::CHAR_W-1:0];
   assign held_waddr = run_ext[HELD_AW-1:0];

   assign printable = !req_payload.end_of_data
                      && (req_payload.in_byte >= pse_pkg::PRINT_LO)
                      && (req_payload.in_byte <= pse_pkg::PRINT_HI);

   always_comb begin
      if (min_ext == '0) begin
         eff_min = CMP_W'(1);
      end else if (min_ext > CMP_W'(MAX_MIN_LEN)) begin
         eff_min = CMP_W'(MAX_MIN_LEN);
      end else begin
         eff_min = min_ext;
      end
      if (max_ext < CMP_W'(2)) begin
         eff_cap = CMP_W'(1);
      end else if (max_ext > CMP_W'(MAX_RUN_LEN)) begin
         eff_cap = CMP_W'(MAX_RUN_LEN - 1);
      end else begin
         eff_cap = max_ext - CMP_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;
      run_count_in    = run_count_ff;
      flush_active_in = flush_active_ff;
      flush_idx_in    = flush_idx_ff;
      flush_nh_in     = flush_nh_ff;
      flush_char_in   = flush_char_ff;
      held_we         = 1'b0;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (flush_active_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            if (flush_idx_ff == flush_nh_ff) begin
               rsp_payload_in  = '{out_char: flush_char_ff, string_end: 1'b0, last: 1'b1};
               flush_active_in = 1'b0;
            end else begin
               rsp_payload_in = '{out_char: held_ff[flush_idx_ff[HELD_AW-1:0]],
                                  string_end: 1'b0, last: 1'b0};
               flush_idx_in   = flush_idx_ff + IDX_W'(1);
            end
         end
      end else if (req_accept) begin
         if (!printable || (run_ext >= eff_cap)) begin
            if (run_ext >= eff_min) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{out_char: '0, string_end: 1'b1, last: 1'b1};
            end
            run_count_in = '0;
         end else if (run_ext >= eff_min) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = '{out_char: cur_char, string_end: 1'b0, last: 1'b1};
            run_count_in   = run_count_ff + CNT_W'(1);
         end else if ((run_ext + CMP_W'(1)) < eff_min) begin
            held_we      = 1'b1;
            run_count_in = run_count_ff + CNT_W'(1);
         end else begin
            rsp_valid_in = 1'b1;
            run_count_in = run_count_ff + CNT_W'(1);
            if (run_ext == '0) begin
               rsp_payload_in = '{out_char: cur_char, string_end: 1'b0, last: 1'b1};
            end else begin
               rsp_payload_in  = '{out_char: held_ff[0], string_end: 1'b0, last: 1'b0};
               flush_active_in = 1'b1;
               flush_idx_in    = IDX_W'(1);
               flush_nh_in     = run_ext[IDX_W-1:0];
               flush_char_in   = cur_char;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff   <= pse_pkg::MIN_LENGTH_RESET;
         max_length_ff   <= pse_pkg::MAX_LENGTH_RESET;
         run_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         flush_active_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               pse_pkg::CSR_MIN_LENGTH: begin
                  min_length_ff <= csr_write_data[pse_pkg::MIN_LENGTH_W-1:0];
               end
               pse_pkg::CSR_MAX_LENGTH: begin
                  max_length_ff <= csr_write_data[pse_pkg::MAX_LENGTH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         run_count_ff    <= run_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         flush_active_ff <= flush_active_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      flush_idx_ff   <= flush_idx_in;
      flush_nh_ff    <= flush_nh_in;
      flush_char_ff  <= flush_char_in;
      if (held_we) begin
         held_ff[held_waddr] <= cur_char;
      end
   end

endmodule

FILE: design/pse_checker.sv
// Port-level checker of the printable string extractor, bound to the top level.
// Depends on pse_pkg and printable_string_extractor_unit_defines.svh.
`include "printable_string_extractor_unit_defines.svh"

module pse_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input pse_pkg::req_type                req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input pse_pkg::rsp_type                rsp_payload
);

   `PSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `PSE_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_valid)
   `PSE_ASSERT_SAME(a_burst_stalls_input, rsp_valid && !rsp_payload.last, req_stall)
   `PSE_ASSERT_NEXT(a_eod_marker_only, req_valid && !req_stall && req_payload.end_of_data, !rsp_valid || rsp_payload.string_end)

endmodule

bind printable_string_extractor_unit pse_checker u_pse_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
